>>> rtl/modified_to_standard_utf8_assert.svh
// Assertion macros shared by the modified_to_standard_utf8 RTL
`ifndef MODIFIED_TO_STANDARD_UTF8_ASSERT_SVH
`define MODIFIED_TO_STANDARD_UTF8_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low
`define M2S_UTF8_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m2s_utf8: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low
`define M2S_UTF8_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("m2s_utf8: next-cycle check failed");

`endif

>>> rtl/m2s_utf8_pkg.sv
// Shared types and constants of the Modified UTF-8 to Standard UTF-8 converter
`default_nettype none

package m2s_utf8_pkg;

	// Most bytes that one input transaction can produce
	localparam int MAX_EMIT   = 6;
	localparam int EMIT_CNT_W = 3;

	// Bytes produced by one input transaction, handed from the converter to the queue
	typedef struct packed {
		logic                          valid;
		logic [EMIT_CNT_W-1:0]         count;
		logic                          bare;
		logic                          last;
		logic                          malformed;
		logic [MAX_EMIT-1:0][7:0]      bytes;
	} batch_t;

endpackage

`default_nettype wire

>>> rtl/m2s_utf8_in_if.sv
// Input channel: one raw Modified UTF-8 byte per transaction
`default_nettype none

interface m2s_utf8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> rtl/m2s_utf8_out_if.sv
// Output channel: one Standard UTF-8 byte or end marker per transaction
`default_nettype none

interface m2s_utf8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;
	logic       malformed;

	modport source (output valid, output out_byte, output byte_valid, output out_last,
		output malformed, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input out_last,
		input malformed, output ready);
endinterface

`default_nettype wire

>>> rtl/m2s_utf8_conv.sv
// Input register, decode state and single-pass byte conversion
`default_nettype none
`include "modified_to_standard_utf8_assert.svh"

module m2s_utf8_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	m2s_utf8_in_if.sink           mutf,
	input  logic                  room,
	output m2s_utf8_pkg::batch_t  batch
);

	localparam int CW = m2s_utf8_pkg::EMIT_CNT_W;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] NIB_MASK   = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] SURR_LEAD  = 8'hED;
	localparam logic [7:0] HIGH_TAG   = 8'hA0;
	localparam logic [7:0] LOW_TAG    = 8'hB0;
	localparam logic [7:0] NUL_LEAD   = 8'hC0;
	localparam logic [7:0] NUL_CONT   = 8'h80;
	localparam logic [7:0] FOUR_BASE  = 8'hF0;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_OPEN,
		PH_HIGH,
		PH_SAW_ED,
		PH_SAW_LOW
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  cont_q, cont_d;
	logic [7:0]  held_q [5];
	logic [7:0]  held_d [5];
	logic        err_q, err_d;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	logic [7:0]    em [m2s_utf8_pkg::MAX_EMIT];
	logic [CW-1:0] n;
	logic          lead_go;
	logic          is_cont;
	logic [4:0]    plane;
	logic [20:0]   code;
	logic [1:0]    flush_n;
	logic [1:0]    tail_n;

	// Bytes already held by an open sequence
	function automatic logic [1:0] open_len(input logic [7:0] lead, input logic [1:0] cont);
		logic two;
		two = (lead & LEAD2_MASK) == LEAD2_TAG;
		return (two || cont == 2'd2) ? 2'd1 : 2'd2;
	endfunction

	assign advance    = valid_s1 && room;
	assign mutf.ready = !valid_s1 || room;

	always_comb begin
		phase_d = phase_q;
		cont_d  = cont_q;
		held_d  = held_q;
		err_d   = err_q;
		em      = '{default: '0};
		n       = '0;
		lead_go = 1'b0;
		is_cont = (byte_s1 & CONT_MASK) == CONT_TAG;
		plane   = {1'b0, held_q[1][3:0]} + 5'd1;
		code    = {plane, held_q[2][5:0], held_q[4][3:0], byte_s1[5:0]};
		flush_n = open_len(held_q[0], cont_q);
		tail_n  = 2'd1;

		case (phase_q)
		PH_HIGH: begin
			if (byte_s1 == SURR_LEAD) begin
				held_d[3] = byte_s1;
				phase_d   = PH_SAW_ED;
			end else begin
				em[n] = held_q[0]; n = n + 1'b1;
				em[n] = held_q[1]; n = n + 1'b1;
				em[n] = held_q[2]; n = n + 1'b1;
				phase_d = PH_IDLE;
				cont_d  = '0;
				lead_go = 1'b1;
			end
		end
		PH_SAW_ED: begin
			if ((byte_s1 & NIB_MASK) == LOW_TAG) begin
				held_d[4] = byte_s1;
				phase_d   = PH_SAW_LOW;
			end else begin
				// release the high half, then reopen ED as a plain lead
				em[n] = held_q[0]; n = n + 1'b1;
				em[n] = held_q[1]; n = n + 1'b1;
				em[n] = held_q[2]; n = n + 1'b1;
				held_d[0] = SURR_LEAD;
				if (is_cont) begin
					held_d[1] = byte_s1;
					cont_d    = 2'd1;
					phase_d   = PH_OPEN;
				end else begin
					err_d   = 1'b1;
					em[n] = SURR_LEAD; n = n + 1'b1;
					phase_d = PH_IDLE;
					cont_d  = '0;
					lead_go = 1'b1;
				end
			end
		end
		PH_SAW_LOW: begin
			if (is_cont) begin
				em[n] = FOUR_BASE | {5'b0, code[20:18]}; n = n + 1'b1;
				em[n] = CONT_TAG | {2'b0, code[17:12]}; n = n + 1'b1;
				em[n] = CONT_TAG | {2'b0, code[11:6]}; n = n + 1'b1;
				em[n] = CONT_TAG | {2'b0, code[5:0]}; n = n + 1'b1;
				phase_d = PH_IDLE;
				cont_d  = '0;
			end else begin
				err_d = 1'b1;
				em[n] = held_q[0]; n = n + 1'b1;
				em[n] = held_q[1]; n = n + 1'b1;
				em[n] = held_q[2]; n = n + 1'b1;
				em[n] = SURR_LEAD; n = n + 1'b1;
				em[n] = held_q[4]; n = n + 1'b1;
				held_d[0] = SURR_LEAD;
				held_d[1] = held_q[4];
				phase_d   = PH_IDLE;
				cont_d    = '0;
				lead_go   = 1'b1;
			end
		end
		PH_OPEN: begin
			if (!is_cont) begin
				err_d = 1'b1;
				em[n] = held_q[0]; n = n + 1'b1;
				if (flush_n == 2'd2) begin
					em[n] = held_q[1]; n = n + 1'b1;
				end
				phase_d = PH_IDLE;
				cont_d  = '0;
				lead_go = 1'b1;
			end else if ((held_q[0] & LEAD2_MASK) == LEAD2_TAG) begin
				held_d[1] = byte_s1;
				phase_d   = PH_IDLE;
				cont_d    = '0;
				if (held_q[0] == NUL_LEAD && byte_s1 == NUL_CONT) begin
					em[n] = 8'h00; n = n + 1'b1;
				end else begin
					em[n] = held_q[0]; n = n + 1'b1;
					em[n] = byte_s1;   n = n + 1'b1;
				end
			end else if (cont_q == 2'd2) begin
				held_d[1] = byte_s1;
				cont_d    = 2'd1;
			end else begin
				held_d[2] = byte_s1;
				cont_d    = '0;
				phase_d   = PH_IDLE;
				if (held_q[0] == SURR_LEAD && (held_q[1] & NIB_MASK) == HIGH_TAG) begin
					// high surrogate: hold for a possible low half
					phase_d = PH_HIGH;
				end else begin
					em[n] = held_q[0]; n = n + 1'b1;
					em[n] = held_q[1]; n = n + 1'b1;
					em[n] = byte_s1;   n = n + 1'b1;
				end
			end
		end
		default: begin
			phase_d = PH_IDLE;
			cont_d  = '0;
			lead_go = 1'b1;
		end
		endcase

		if (lead_go) begin
			if (!byte_s1[7]) begin
				em[n] = byte_s1; n = n + 1'b1;
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_TAG) begin
				held_d[0] = byte_s1;
				cont_d    = 2'd1;
				phase_d   = PH_OPEN;
			end else if ((byte_s1 & NIB_MASK) == LEAD3_TAG) begin
				held_d[0] = byte_s1;
				cont_d    = 2'd2;
				phase_d   = PH_OPEN;
			end else begin
				// drop a bad lead byte
				err_d = 1'b1;
			end
		end

		if (last_s1) begin
			tail_n = open_len(held_d[0], cont_d);
			case (phase_d)
			PH_HIGH: begin
				em[n] = held_d[0]; n = n + 1'b1;
				em[n] = held_d[1]; n = n + 1'b1;
				em[n] = held_d[2]; n = n + 1'b1;
			end
			PH_SAW_ED: begin
				err_d = 1'b1;
				em[n] = held_d[0]; n = n + 1'b1;
				em[n] = held_d[1]; n = n + 1'b1;
				em[n] = held_d[2]; n = n + 1'b1;
				em[n] = held_d[3]; n = n + 1'b1;
			end
			PH_SAW_LOW: begin
				err_d = 1'b1;
				em[n] = held_d[0]; n = n + 1'b1;
				em[n] = held_d[1]; n = n + 1'b1;
				em[n] = held_d[2]; n = n + 1'b1;
				em[n] = held_d[3]; n = n + 1'b1;
				em[n] = held_d[4]; n = n + 1'b1;
			end
			PH_OPEN: begin
				err_d = 1'b1;
				em[n] = held_d[0]; n = n + 1'b1;
				if (tail_n == 2'd2) begin
					em[n] = held_d[1]; n = n + 1'b1;
				end
			end
			default: begin
			end
			endcase
			phase_d = PH_IDLE;
			cont_d  = '0;
		end
	end

	always_comb begin
		batch.valid     = advance;
		batch.last      = last_s1;
		batch.malformed = err_d;
		batch.bare      = last_s1 && n == '0;
		batch.count     = batch.bare ? CW'(1) : n;
		for (int k = 0; k < m2s_utf8_pkg::MAX_EMIT; k++) begin
			batch.bytes[k] = em[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cont_q   <= '0;
			err_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				cont_q  <= cont_d;
				err_q   <= last_s1 ? 1'b0 : err_d;
			end
			if (mutf.ready) begin
				valid_s1 <= mutf.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_q <= held_d;
		end
		if (mutf.ready && mutf.valid) begin
			byte_s1 <= mutf.in_byte;
			last_s1 <= mutf.in_last;
		end
	end

	`M2S_UTF8_ASSERT_NOW(a_open_owes_bytes, phase_q == PH_OPEN, cont_q != 2'd0)
	`M2S_UTF8_ASSERT_NEXT(a_last_clears, valid_s1 && last_s1 && room, phase_q == PH_IDLE && !err_q)
	`M2S_UTF8_ASSERT_NOW(a_bare_is_single, batch.valid && batch.bare, batch.count == CW'(1) && batch.last)

endmodule

`default_nettype wire

>>> rtl/m2s_utf8_fifo.sv
// Result queue: takes a whole batch of bytes per cycle, releases one byte per transaction
`default_nettype none
`include "modified_to_standard_utf8_assert.svh"

module m2s_utf8_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  m2s_utf8_pkg::batch_t  batch,
	output logic                  room,
	m2s_utf8_out_if.source        sutf
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = m2s_utf8_pkg::EMIT_CNT_W;

	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       last;
		logic       malformed;
	} entry_t;

	entry_t            mem_q [DEPTH];
	entry_t            slot [m2s_utf8_pkg::MAX_EMIT];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              push, pop;

	assign push = batch.valid && batch.count != '0;
	assign pop  = sutf.valid && sutf.ready;
	assign room = cnt_q <= CNT_W'(DEPTH - m2s_utf8_pkg::MAX_EMIT);

	always_comb begin
		for (int k = 0; k < m2s_utf8_pkg::MAX_EMIT; k++) begin
			slot[k].data       = batch.bytes[k];
			slot[k].data_valid = !batch.bare;
			slot[k].last       = batch.last && CW'(k + 1) == batch.count;
			slot[k].malformed  = batch.malformed;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < m2s_utf8_pkg::MAX_EMIT; k++) begin
				if (CW'(k) < batch.count) begin
					mem_q[wr_ptr_q + PTR_W'(k)] <= slot[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(batch.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (push ? CNT_W'(batch.count) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	assign sutf.valid      = cnt_q != '0;
	assign sutf.out_byte   = mem_q[rd_ptr_q].data;
	assign sutf.byte_valid = mem_q[rd_ptr_q].data_valid;
	assign sutf.out_last   = mem_q[rd_ptr_q].last;
	assign sutf.malformed  = mem_q[rd_ptr_q].malformed;

	`M2S_UTF8_ASSERT_NOW(a_batch_has_room, batch.valid, room)
	`M2S_UTF8_ASSERT_NEXT(a_push_grows, push && !pop, cnt_q == $past(cnt_q) + CNT_W'($past(batch.count)))
	`M2S_UTF8_ASSERT_NEXT(a_pop_shrinks, pop && !push, cnt_q == $past(cnt_q) - CNT_W'(1))

endmodule

`default_nettype wire

>>> rtl/modified_to_standard_utf8.sv
// Modified UTF-8 to Standard UTF-8 stream converter, top level
//
// mutf carries the raw string, one byte per transaction, in_last on the final byte.
// sutf carries the converted bytes, one per transaction. byte_valid is low only on a
// bare end marker, sent when the final input byte yields no byte. out_last marks the
// final result of a string; malformed is the sticky error flag of that string so far,
// and it is cleared with the string end.
// A byte accepted on mutf is registered in the input register, converted from there
// and written to the result queue when the queue has room; the queue then offers its
// results on sutf. Throughput: one input byte per cycle; one input byte yields zero
// to six result bytes, written to the queue together and drained at one per cycle
// while sutf is ready. mutf.ready drops while a byte waits in the input register and
// the queue has fewer than six free entries, so the sustained rate is set by the
// single output port of the queue: one result byte per cycle. A stall on sutf holds
// the head of the queue; input keeps flowing until the queue lacks room for a batch.
// Reset empties the queue, drops any byte in flight and returns the decoder to idle
// with the error flag clear. QUEUE_DEPTH must be a power of two, at least 8.
`default_nettype none

module modified_to_standard_utf8 #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	m2s_utf8_in_if.sink     mutf,
	m2s_utf8_out_if.source  sutf
);

	m2s_utf8_pkg::batch_t batch;
	logic                 room;

	m2s_utf8_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.mutf   (mutf),
		.room   (room),
		.batch  (batch)
	);

	m2s_utf8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (batch),
		.room   (room),
		.sutf   (sutf)
	);

endmodule

`default_nettype wire

>>> tb/tb_modified_to_standard_utf8.sv
// Testbench for the Modified UTF-8 to Standard UTF-8 converter: random strings, scoreboard
`timescale 1ns / 100ps

package m2s_utf8_tb_pkg;

	localparam logic [7:0] SURR_LEAD  = 8'hED;
	localparam logic [7:0] HIGH_TAG   = 8'hA0;
	localparam logic [7:0] LOW_TAG    = 8'hB0;
	localparam logic [7:0] TWO_LEAD   = 8'hC0;
	localparam logic [7:0] THREE_LEAD = 8'hE0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	typedef enum logic [2:0] {CV_IDLE, CV_OPEN, CV_HIGH, CV_SAW_ED, CV_SAW_LOW} cv_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
		logic       malformed;
	} sutf_beat_t;

	class sutf_scoreboard;
		cv_phase_t  phase;
		logic [1:0] owed;
		logic [7:0] held [5];
		bit         err_flag;
		logic [7:0] fresh [$];
		sutf_beat_t std_bytes_due [$];
		int         fail_count;

		function new();
			phase = CV_IDLE;
			owed = 2'd0;
			err_flag = 1'b0;
			fail_count = 0;
			foreach (held[i]) held[i] = 8'h00;
		endfunction

		function int pending();
			return std_bytes_due.size();
		endfunction

		function void emit(logic [7:0] b);
			if (fresh.size() < 8) fresh.push_back(b);
		endfunction

		function int open_len();
			int total;
			total = ((held[0] & 8'hE0) == TWO_LEAD) ? 2 : 3;
			return total - int'(owed);
		endfunction

		function void flush_open();
			int n;
			n = open_len();
			for (int i = 0; i < n && i < 3; i++) emit(held[i]);
			phase = CV_IDLE;
			owed = 2'd0;
		endfunction

		function void flush_held(int n);
			for (int i = 0; i < n && i < 5; i++) emit(held[i]);
			phase = CV_IDLE;
			owed = 2'd0;
		endfunction

		function void take_lead(logic [7:0] b);
			if (b < 8'h80) begin
				emit(b);
			end else if ((b & 8'hE0) == TWO_LEAD) begin
				held[0] = b;
				owed = 2'd1;
				phase = CV_OPEN;
			end else if ((b & 8'hF0) == THREE_LEAD) begin
				held[0] = b;
				owed = 2'd2;
				phase = CV_OPEN;
			end else begin
				err_flag = 1'b1;
			end
		endfunction

		// One byte while idle or inside a single open sequence
		function void plain_byte(logic [7:0] b);
			int n;
			if (phase != CV_OPEN) begin
				take_lead(b);
				return;
			end
			if ((b & 8'hC0) != CONT_TAG) begin
				err_flag = 1'b1;
				flush_open();
				take_lead(b);
				return;
			end
			n = open_len();
			if (n < 1 || n > 2) begin
				flush_open();
				return;
			end
			held[n] = b;
			owed = owed - 2'd1;
			if (owed != 2'd0) return;
			phase = CV_IDLE;
			if ((held[0] & 8'hE0) == TWO_LEAD) begin
				if (held[0] == TWO_LEAD && b == CONT_TAG) begin
					emit(8'h00);
				end else begin
					emit(held[0]);
					emit(b);
				end
			end else if (held[0] == SURR_LEAD && (held[1] & 8'hF0) == HIGH_TAG) begin
				phase = CV_HIGH;
			end else begin
				emit(held[0]);
				emit(held[1]);
				emit(b);
			end
		endfunction

		function void emit_pair(logic [7:0] b);
			logic [31:0] u;
			u = ({28'd0, held[1][3:0]} + 32'd1) << 16;
			u = u + ({26'd0, held[2][5:0]} << 10);
			u = u + ({28'd0, held[4][3:0]} << 6);
			u = u + {26'd0, b[5:0]};
			emit({5'b11110, u[20:18]});
			emit({2'b10, u[17:12]});
			emit({2'b10, u[11:6]});
			emit({2'b10, u[5:0]});
			phase = CV_IDLE;
			owed = 2'd0;
		endfunction

		// Work out the output bytes of one accepted input transaction
		function void take_mutf(logic [7:0] b, logic last);
			logic [7:0] lowb;
			int cnt;
			sutf_beat_t beat;
			fresh.delete();
			case (phase)
				CV_HIGH: begin
					if (b == SURR_LEAD) begin
						held[3] = b;
						phase = CV_SAW_ED;
					end else begin
						flush_held(3);
						plain_byte(b);
					end
				end
				CV_SAW_ED: begin
					if ((b & 8'hF0) == LOW_TAG) begin
						held[4] = b;
						phase = CV_SAW_LOW;
					end else begin
						flush_held(3);
						plain_byte(SURR_LEAD);
						plain_byte(b);
					end
				end
				CV_SAW_LOW: begin
					if ((b & 8'hC0) == CONT_TAG) begin
						emit_pair(b);
					end else begin
						err_flag = 1'b1;
						lowb = held[4];
						flush_held(3);
						plain_byte(SURR_LEAD);
						plain_byte(lowb);
						plain_byte(b);
					end
				end
				CV_OPEN: plain_byte(b);
				default: begin
					phase = CV_IDLE;
					owed = 2'd0;
					plain_byte(b);
				end
			endcase

			if (last) begin
				case (phase)
					CV_HIGH: flush_held(3);
					CV_SAW_ED: begin
						err_flag = 1'b1;
						flush_held(4);
					end
					CV_SAW_LOW: begin
						err_flag = 1'b1;
						flush_held(5);
					end
					CV_OPEN: begin
						err_flag = 1'b1;
						flush_open();
					end
					default: ;
				endcase
			end

			cnt = (fresh.size() > m2s_utf8_pkg::MAX_EMIT) ? m2s_utf8_pkg::MAX_EMIT : fresh.size();
			for (int k = 0; k < cnt; k++) begin
				beat.out_byte = fresh[k];
				beat.byte_valid = 1'b1;
				beat.out_last = last && (k == cnt - 1);
				beat.malformed = err_flag;
				std_bytes_due.push_back(beat);
			end
			if (last) begin
				// bare end marker when the final byte yields nothing
				if (cnt == 0) begin
					beat.out_byte = 8'h00;
					beat.byte_valid = 1'b0;
					beat.out_last = 1'b1;
					beat.malformed = err_flag;
					std_bytes_due.push_back(beat);
				end
				phase = CV_IDLE;
				owed = 2'd0;
				err_flag = 1'b0;
			end
		endfunction

		function void note_fail(string what, sutf_beat_t want, sutf_beat_t got);
			fail_count++;
			if (fail_count <= 10)
				$display({"%0t %s: expected byte %h valid %b last %b malformed %b,",
					" got byte %h valid %b last %b malformed %b"},
					$realtime, what, want.out_byte, want.byte_valid, want.out_last,
					want.malformed, got.out_byte, got.byte_valid, got.out_last,
					got.malformed);
		endfunction

		function void check_sutf(sutf_beat_t got);
			sutf_beat_t want;
			if (std_bytes_due.size() == 0) begin
				note_fail("unexpected transaction", '0, got);
				return;
			end
			want = std_bytes_due.pop_front();
			if (got !== want) note_fail("mismatch", want, got);
		endfunction
	endclass

endpackage

module tb_modified_to_standard_utf8;

	localparam int HOLD_CYCLES = 300;
	localparam int BYTES_PER_PHASE = 100;

	logic clk;
	logic arst_n;

	m2s_utf8_in_if  mutf();
	m2s_utf8_out_if sutf();

	modified_to_standard_utf8 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.mutf   (mutf),
		.sutf   (sutf)
	);

	m2s_utf8_tb_pkg::sutf_scoreboard sb = new();

	int         src_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_asks = 0;
	logic [7:0] str_q [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: check each transaction, stall at random, and hold off on request
	initial begin : sutf_sink
		int hold_seen;
		int hold_left;
		m2s_utf8_tb_pkg::sutf_beat_t got;
		hold_seen = 0;
		hold_left = 0;
		sutf.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sutf.valid === 1'b1 && sutf.ready === 1'b1) begin
				got = '{sutf.out_byte, sutf.byte_valid, sutf.out_last, sutf.malformed};
				sb.check_sutf(got);
			end
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				sutf.ready <= 1'b0;
			end else begin
				sutf.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic offer_byte(input logic [7:0] b, input logic last);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			mutf.valid <= 1'b0;
			@(posedge clk);
		end
		mutf.valid <= 1'b1;
		mutf.in_byte <= b;
		mutf.in_last <= last;
		@(posedge clk);
		while (mutf.ready !== 1'b1) @(posedge clk);
		sb.take_mutf(b, last);
	endtask

	task automatic send_str();
		for (int i = 0; i < str_q.size(); i++) offer_byte(str_q[i], i == str_q.size() - 1);
	endtask

	// Append one Modified UTF-8 token: mostly well formed, some noise and broken sequences
	function automatic void add_token();
		int r;
		logic [19:0] u;
		logic [15:0] cp;
		r = $urandom_range(99);
		u = 20'($urandom);
		cp = 16'($urandom);
		if (r < 28) begin
			str_q.push_back(8'($urandom_range(0, 127)));
		end else if (r < 34) begin
			str_q.push_back(m2s_utf8_tb_pkg::TWO_LEAD);
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG);
		end else if (r < 48) begin
			cp = 16'($urandom_range(16'h0080, 16'h07FF));
			str_q.push_back(m2s_utf8_tb_pkg::TWO_LEAD | {3'b000, cp[10:6]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, cp[5:0]});
		end else if (r < 62) begin
			if (cp < 16'h0800) cp = cp | 16'h0800;
			str_q.push_back(m2s_utf8_tb_pkg::THREE_LEAD | {4'h0, cp[15:12]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, cp[11:6]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, cp[5:0]});
		end else if (r < 80) begin
			str_q.push_back(m2s_utf8_tb_pkg::SURR_LEAD);
			str_q.push_back(m2s_utf8_tb_pkg::HIGH_TAG | {4'h0, u[19:16]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, u[15:10]});
			str_q.push_back(m2s_utf8_tb_pkg::SURR_LEAD);
			str_q.push_back(m2s_utf8_tb_pkg::LOW_TAG | {4'h0, u[9:6]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, u[5:0]});
		end else if (r < 84) begin
			str_q.push_back(m2s_utf8_tb_pkg::SURR_LEAD);
			str_q.push_back(m2s_utf8_tb_pkg::HIGH_TAG | {4'h0, u[19:16]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, u[15:10]});
		end else if (r < 87) begin
			str_q.push_back(m2s_utf8_tb_pkg::SURR_LEAD);
			str_q.push_back(m2s_utf8_tb_pkg::LOW_TAG | {4'h0, u[9:6]});
			str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, u[5:0]});
		end else if (r < 94) begin
			str_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			// lead with at most one continuation byte, then possibly anything
			str_q.push_back(8'($urandom_range(8'hC2, 8'hEF)));
			if ($urandom_range(1)) str_q.push_back(m2s_utf8_tb_pkg::CONT_TAG | {2'b00, u[5:0]});
			if ($urandom_range(1)) str_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin : mutf_source
		int src_pcts [4];
		int sink_pcts [4];
		int sent;
		int tokens;
		src_pcts = '{0, 77, 0, 20};
		sink_pcts = '{0, 0, 77, 20};
		arst_n <= 1'b0;
		mutf.valid <= 1'b0;
		mutf.in_byte <= 8'h00;
		mutf.in_last <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes, then a bad lead dropped at the end
		str_q = '{8'h00, 8'h7F, 8'hFF};
		send_str();
		// two-byte null
		str_q = '{m2s_utf8_tb_pkg::TWO_LEAD, m2s_utf8_tb_pkg::CONT_TAG};
		send_str();
		// highest supplementary code point
		str_q = '{8'hED, 8'hAF, 8'hBF, 8'hED, 8'hBF, 8'hBF};
		send_str();
		// bad continuation, then a bad lead leaving only a bare end marker
		str_q = '{8'hE4, 8'h41, 8'h80};
		send_str();
		// low half broken off by a non-continuation byte
		str_q = '{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h41};
		send_str();
		// string ends after the second ED
		str_q = '{8'hED, 8'hA0, 8'h80, 8'hED};
		send_str();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = src_pcts[ph];
			stall_pct = sink_pcts[ph];
			// hold the receiver off while the sender keeps offering
			if (ph == 0) hold_asks++;
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				str_q.delete();
				tokens = $urandom_range(1, 10);
				repeat (tokens) add_token();
				send_str();
				sent += str_q.size();
			end
		end
		mutf.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
